// File: rtl/sti_pkg.sv
package sti_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int FIELD_WIDTH = 32;
   localparam int INDEX_FIELD_WIDTH = 8;
   localparam int COUNT_FIELD_WIDTH = 9;

   localparam logic [1:0] ACTION_LOAD     = 2'd0;
   localparam logic [1:0] ACTION_K_TO_MV  = 2'd1;
   localparam logic [1:0] ACTION_MV_TO_K  = 2'd2;

   localparam logic [1:0] STATUS_CONVERTED = 2'd0;
   localparam logic [1:0] STATUS_RANGE     = 2'd1;
   localparam logic [1:0] STATUS_LOADED    = 2'd2;

   typedef struct packed {
      logic [1:0]                   action;
      logic [INDEX_FIELD_WIDTH-1:0] entry_index;
      logic [FIELD_WIDTH-1:0]       entry_kelvin;
      logic [FIELD_WIDTH-1:0]       entry_millivolts;
      logic [FIELD_WIDTH-1:0]       query_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [FIELD_WIDTH-1:0] result_value;
   } rsp_item_type;

endpackage

// File: rtl/sti_ram.sv
module sti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sti_frac.sv
// floor(a * t / d) for t <= d, d > 0: one quotient bit per add and reduce pair
module sti_frac import sti_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] oper_a,
   input  logic [VALUE_WIDTH-1:0] oper_t,
   input  logic [VALUE_WIDTH-1:0] oper_d,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quot
);

   localparam int VW  = VALUE_WIDTH;
   localparam int SW  = VW + 2;
   localparam int CW  = $clog2(VW);

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_ADD    = 3'b010,
      F_REDUCE = 3'b100
   } frac_state_type;

   frac_state_type state_ff, state_in;
   logic [VW-1:0]  a_ff, a_in;
   logic [VW-1:0]  t_ff, t_in;
   logic [VW-1:0]  d_ff, d_in;
   logic [VW:0]    d2_ff, d2_in;
   logic [VW-1:0]  r_ff, r_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [VW-1:0]  q_ff, q_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           done_ff, done_in;
   logic [1:0]     digit;
   logic           ge1;
   logic           ge2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      t_ff   <= t_in;
      d_ff   <= d_in;
      d2_ff  <= d2_in;
      r_ff   <= r_in;
      s_ff   <= s_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign ge1 = s_ff >= SW'(d_ff);
   assign ge2 = s_ff >= SW'(d2_ff);

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      t_in     = t_ff;
      d_in     = d_ff;
      d2_in    = d2_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      digit    = 2'd0;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               a_in     = oper_a;
               t_in     = oper_t;
               d_in     = oper_d;
               d2_in    = {oper_d, 1'b0};
               r_in     = '0;
               q_in     = '0;
               cnt_in   = CW'(VW - 1);
               state_in = F_ADD;
            end
         end
         F_ADD: begin
            s_in     = SW'({r_ff, 1'b0}) + (a_ff[VW-1] ? SW'(t_ff) : SW'(0));
            a_in     = {a_ff[VW-2:0], 1'b0};
            state_in = F_REDUCE;
         end
         F_REDUCE: begin
            if (ge2) begin
               r_in  = VW'(s_ff - SW'(d2_ff));
               digit = 2'd2;
            end else if (ge1) begin
               r_in  = VW'(s_ff - SW'(d_ff));
               digit = 2'd1;
            end else begin
               r_in  = VW'(s_ff);
            end
            q_in = {q_ff[VW-2:0], 1'b0} + VW'(digit);
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = F_ADD;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// File: rtl/sensor_table_interpolator_core.sv
// Two-column calibration table (kelvin rising, diode millivolts falling with the row)
// with piecewise-linear conversion in either direction. A load item writes one row
// and answers with status LOADED. A convert item reads the two end rows for the range check,
// binary-searches the bracketing rows (one table read per step, ceil(log2(rows-1))
// steps), then scales the column difference with a serial shift-add/reduce unit that
// yields one quotient bit per add and reduce step pair. One item is in flight at a time.
// The table is not cleared by reset, and the csr write sets the number of rows in use,
// clamped to 2..TABLE_DEPTH.
module sensor_table_interpolator_core import sti_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  req_item_type                 req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rsp_item_type                 rsp_item,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [COUNT_FIELD_WIDTH-1:0] csr_data
);

   localparam int VW     = VALUE_WIDTH;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W  = ((IDX_W > INDEX_FIELD_WIDTH) ? IDX_W : INDEX_FIELD_WIDTH) + 1;
   localparam int CMP_W  = ((CNT_W > COUNT_FIELD_WIDTH) ? CNT_W : COUNT_FIELD_WIDTH) + 1;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_RD_FIRST = 7'b0000010,
      S_RD_LAST  = 7'b0000100,
      S_SEARCH   = 7'b0001000,
      S_SETUP    = 7'b0010000,
      S_DIVIDE   = 7'b0100000,
      S_RESP     = 7'b1000000
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             mv_mode_ff, mv_mode_in;
   logic [VW-1:0]    query_ff, query_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [VW-1:0]    lok_ff, lok_in;
   logic [VW-1:0]    lom_ff, lom_in;
   logic [VW-1:0]    hik_ff, hik_in;
   logic [VW-1:0]    him_ff, him_in;
   logic [VW-1:0]    to_lo_ff, to_lo_in;
   logic             neg_ff, neg_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic               req_accept;
   logic               wr_en;
   logic [EXT_W-1:0]   idx_ext;
   logic [2*VW-1:0]    wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [2*VW-1:0]    rd_data;
   logic [VW-1:0]      rd_k;
   logic [VW-1:0]      rd_m;
   logic [CMP_W-1:0]   csr_ext;
   logic [IDX_W-1:0]   span;
   logic [IDX_W-1:0]   nlo;
   logic [IDX_W-1:0]   nhi;
   logic               go_hi;
   logic [VW-1:0]      su_t;
   logic [VW-1:0]      su_d;
   logic [VW-1:0]      su_tlo;
   logic [VW-1:0]      su_thi;
   logic               su_neg;
   logic [VW-1:0]      su_a;
   logic               frac_start;
   logic               frac_done;
   logic [VW-1:0]      frac_quot;
   logic [VW-1:0]      conv_value;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_item   = rsp_ff;
   assign csr_ready  = 1'b1;

   // row load with an index inside the table goes straight into it on accept
   assign idx_ext = EXT_W'(req_item.entry_index);
   assign wr_en   = req_accept && (req_item.action == ACTION_LOAD)
                    && (idx_ext < EXT_W'(TABLE_DEPTH));
   assign wr_data = {VW'(req_item.entry_kelvin), VW'(req_item.entry_millivolts)};

   sti_ram #(
      .WIDTH (2 * VW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_k = rd_data[2*VW-1:VW];
   assign rd_m = rd_data[VW-1:0];

   sti_frac #(
      .VALUE_WIDTH (VW)
   ) u_frac (
      .clock  (clock),
      .reset  (reset),
      .start  (frac_start),
      .oper_a (su_a),
      .oper_t (su_t),
      .oper_d (su_d),
      .done   (frac_done),
      .quot   (frac_quot)
   );

   assign csr_ext = CMP_W'(csr_data);

   always_comb begin
      last_in = last_ff;
      if (csr_valid && csr_ready) begin
         if (csr_ext < CMP_W'(2)) begin
            last_in = IDX_W'(1);
         end else if (csr_ext > CMP_W'(TABLE_DEPTH)) begin
            last_in = IDX_W'(TABLE_DEPTH - 1);
         end else begin
            last_in = IDX_W'(csr_ext - CMP_W'(1));
         end
      end
   end

   // lerp operands from the bracketing rows
   always_comb begin
      if (mv_mode_ff) begin
         su_t   = lom_ff - query_ff;
         su_d   = lom_ff - him_ff;
         su_tlo = lok_ff;
         su_thi = hik_ff;
      end else begin
         su_t   = query_ff - lok_ff;
         su_d   = hik_ff - lok_ff;
         su_tlo = lom_ff;
         su_thi = him_ff;
      end
      su_neg = su_thi < su_tlo;
      su_a   = su_neg ? (su_tlo - su_thi) : (su_thi - su_tlo);
   end

   assign conv_value = neg_ff ? (to_lo_ff - frac_quot) : (to_lo_ff + frac_quot);

   assign go_hi = mv_mode_ff ? !(query_ff < rd_m) : (query_ff < rd_k);

   always_comb begin
      nlo = lo_ff;
      nhi = hi_ff;
      if (state_ff == S_SEARCH) begin
         if (go_hi) begin
            nhi = mid_ff;
         end else begin
            nlo = mid_ff;
         end
      end
      span = nhi - nlo;
   end

   always_comb begin
      state_in   = state_ff;
      mv_mode_in = mv_mode_ff;
      query_in   = query_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      lok_in     = lok_ff;
      lom_in     = lom_ff;
      hik_in     = hik_ff;
      him_in     = him_ff;
      to_lo_in   = to_lo_ff;
      neg_in     = neg_ff;
      rsp_in     = rsp_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      frac_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mv_mode_in = (req_item.action == ACTION_MV_TO_K);
               query_in   = VW'(req_item.query_value);
               lo_in      = '0;
               hi_in      = last_ff;
               unique case (req_item.action) inside
                  ACTION_LOAD: begin
                     rsp_in   = '{status: STATUS_LOADED, result_value: '0};
                     state_in = S_RESP;
                  end
                  ACTION_K_TO_MV, ACTION_MV_TO_K: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = S_RD_FIRST;
                  end
                  default: begin
                     rsp_in   = '{status: STATUS_RANGE, result_value: '0};
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RD_FIRST: begin
            lok_in   = rd_k;
            lom_in   = rd_m;
            rd_en    = 1'b1;
            rd_addr  = last_ff;
            state_in = S_RD_LAST;
         end
         S_RD_LAST: begin
            hik_in = rd_k;
            him_in = rd_m;
            if (mv_mode_ff ? ((query_ff > lom_ff) || (query_ff < rd_m))
                           : ((query_ff < lok_ff) || (query_ff > rd_k))) begin
               rsp_in   = '{status: STATUS_RANGE, result_value: '0};
               state_in = S_RESP;
            end else if (span > IDX_W'(1)) begin
               mid_in   = nlo + (span >> 1);
               rd_en    = 1'b1;
               rd_addr  = nlo + (span >> 1);
               state_in = S_SEARCH;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SEARCH: begin
            lo_in = nlo;
            hi_in = nhi;
            if (go_hi) begin
               hik_in = rd_k;
               him_in = rd_m;
            end else begin
               lok_in = rd_k;
               lom_in = rd_m;
            end
            if (span > IDX_W'(1)) begin
               mid_in  = nlo + (span >> 1);
               rd_en   = 1'b1;
               rd_addr = nlo + (span >> 1);
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            to_lo_in = su_tlo;
            neg_in   = su_neg;
            if (su_d == '0) begin
               rsp_in   = '{status: STATUS_CONVERTED, result_value: FIELD_WIDTH'(su_tlo)};
               state_in = S_RESP;
            end else begin
               frac_start = 1'b1;
               state_in   = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (frac_done) begin
               rsp_in   = '{status: STATUS_CONVERTED,
                            result_value: FIELD_WIDTH'(conv_value)};
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= IDX_W'(1);
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_mode_ff <= mv_mode_in;
      query_ff   <= query_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      lok_ff     <= lok_in;
      lom_ff     <= lom_in;
      hik_ff     <= hik_in;
      him_ff     <= him_in;
      to_lo_ff   <= to_lo_in;
      neg_ff     <= neg_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// File: verif/tb_sensor_table_interpolator_core.sv
module tb_sensor_table_interpolator_core import sti_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam int ROWS_MAX = 256;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_FIELD_WIDTH-1:0] csr_data = '0;

   // predictor copy of the table, updated on accepted items
   logic [FIELD_WIDTH-1:0] cal_kelvin [ROWS_MAX];
   logic [FIELD_WIDTH-1:0] cal_millivolts [ROWS_MAX];
   int cal_rows = 2;
   rsp_item_type awaited[$];
   rsp_item_type due;

   // stimulus copy of the table, used to aim queries
   logic [FIELD_WIDTH-1:0] plan_kelvin [ROWS_MAX];
   logic [FIELD_WIDTH-1:0] plan_millivolts [ROWS_MAX];
   int plan_rows = 2;

   bit idle_on = 1'b1;
   int stall_left = 0;
   int idle_cycles = 0;
   int unsigned error_count = 0;
   int unsigned loaded_count = 0;
   int unsigned converted_count = 0;
   int unsigned range_count = 0;
   int unsigned csr_writes = 0;

   sensor_table_interpolator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      for (int r = 0; r < ROWS_MAX; r++) begin
         cal_kelvin[r] = '0;
         cal_millivolts[r] = '0;
         plan_kelvin[r] = '0;
         plan_millivolts[r] = '0;
      end
   end

   function automatic int effective_rows(logic [COUNT_FIELD_WIDTH-1:0] v);
      if (v < 2) return 2;
      if (v > ROWS_MAX) return ROWS_MAX;
      return int'(v);
   endfunction

   // to_lo + (to_hi - to_lo) * t / d, truncated toward zero
   function automatic logic [FIELD_WIDTH-1:0] blend(logic [FIELD_WIDTH-1:0] to_lo,
                                                   logic [FIELD_WIDTH-1:0] to_hi,
                                                   logic [FIELD_WIDTH-1:0] t,
                                                   logic [FIELD_WIDTH-1:0] d);
      logic [63:0] frac;
      if (d == 0) return to_lo;
      if (to_hi >= to_lo) begin
         frac = (64'(to_hi - to_lo) * 64'(t)) / 64'(d);
         return to_lo + frac[FIELD_WIDTH-1:0];
      end
      frac = (64'(to_lo - to_hi) * 64'(t)) / 64'(d);
      return to_lo - frac[FIELD_WIDTH-1:0];
   endfunction

   function automatic rsp_item_type interpolate_item(req_item_type it);
      rsp_item_type r;
      int lo;
      int hi;
      int mid;
      logic [FIELD_WIDTH-1:0] q;
      r.status = STATUS_RANGE;
      r.result_value = '0;
      lo = 0;
      hi = cal_rows - 1;
      q = it.query_value;
      case (it.action)
         ACTION_LOAD: begin
            cal_kelvin[it.entry_index] = it.entry_kelvin;
            cal_millivolts[it.entry_index] = it.entry_millivolts;
            r.status = STATUS_LOADED;
         end
         ACTION_K_TO_MV: begin
            if (q >= cal_kelvin[0] && q <= cal_kelvin[hi]) begin
               while (hi - lo > 1) begin
                  mid = lo + (hi - lo) / 2;
                  if (q < cal_kelvin[mid]) hi = mid;
                  else lo = mid;
               end
               r.status = STATUS_CONVERTED;
               r.result_value = blend(cal_millivolts[lo], cal_millivolts[hi],
                                      q - cal_kelvin[lo], cal_kelvin[hi] - cal_kelvin[lo]);
            end
         end
         ACTION_MV_TO_K: begin
            if (q <= cal_millivolts[0] && q >= cal_millivolts[hi]) begin
               while (hi - lo > 1) begin
                  mid = lo + (hi - lo) / 2;
                  if (q < cal_millivolts[mid]) lo = mid;
                  else hi = mid;
               end
               r.status = STATUS_CONVERTED;
               r.result_value = blend(cal_kelvin[lo], cal_kelvin[hi],
                                      cal_millivolts[lo] - q,
                                      cal_millivolts[lo] - cal_millivolts[hi]);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // check results, then predict for the accepted item and any csr write
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding, status %0d value %h",
                                         rsp_item.status, rsp_item.result_value));
            end else begin
               due = awaited.pop_front();
               if (rsp_item.status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_item.status, due.status));
               if (rsp_item.result_value !== due.result_value)
                  report_mismatch($sformatf("result_value %h, expected %h",
                                            rsp_item.result_value, due.result_value));
               case (due.status)
                  STATUS_LOADED:    loaded_count++;
                  STATUS_CONVERTED: converted_count++;
                  default:          range_count++;
               endcase
            end
         end
         if (csr_valid && csr_ready) begin
            cal_rows = effective_rows(csr_data);
            csr_writes++;
         end
         if (req_valid && !req_stall) awaited.push_back(interpolate_item(req_item));
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("** sensor_table_interpolator_core: FAILED **");
            $finish;
         end
      end
   end

   function automatic logic [FIELD_WIDTH-1:0] pick(logic [FIELD_WIDTH-1:0] lo,
                                                  logic [FIELD_WIDTH-1:0] hi);
      logic [63:0] span;
      span = 64'(hi) - 64'(lo) + 64'd1;
      return lo + FIELD_WIDTH'({$urandom, $urandom} % span);
   endfunction

   function automatic logic [63:0] random_step(logic [63:0] max, int flat_pct);
      if ($urandom_range(0, 99) < flat_pct) return 64'd0;
      return {$urandom, $urandom} % (max + 64'd1);
   endfunction

   task automatic send_item(req_item_type it);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_row_count(logic [COUNT_FIELD_WIDTH-1:0] v);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      plan_rows = effective_rows(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_row(int row, logic [FIELD_WIDTH-1:0] kv, logic [FIELD_WIDTH-1:0] mv);
      req_item_type it;
      it.action = ACTION_LOAD;
      it.entry_index = INDEX_FIELD_WIDTH'(row);
      it.entry_kelvin = kv;
      it.entry_millivolts = mv;
      it.query_value = $urandom;
      plan_kelvin[row] = kv;
      plan_millivolts[row] = mv;
      send_item(it);
   endtask

   task automatic convert(logic [1:0] act, logic [FIELD_WIDTH-1:0] q);
      req_item_type it;
      it.action = act;
      it.entry_index = INDEX_FIELD_WIDTH'($urandom);
      it.entry_kelvin = $urandom;
      it.entry_millivolts = $urandom;
      it.query_value = q;
      send_item(it);
   endtask

   // kelvin rising and millivolts falling, with some flat steps
   task automatic load_sorted_table(int rows, int flat_pct);
      logic [63:0] kv;
      logic [63:0] mv;
      logic [63:0] kmax;
      logic [63:0] mmax;
      kv = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(0, 32'h3FFF_FFFF));
      mv = $urandom_range(0, 1) ? 64'hFFFF_FFFF
                                : 64'hFFFF_FFFF - 64'($urandom_range(0, 32'h3FFF_FFFF));
      kmax = (64'hFFFF_FFFF - kv) / 64'(rows - 1);
      mmax = mv / 64'(rows - 1);
      if ($urandom_range(0, 3) == 0) begin
         if (kmax > 64) kmax = 64;
         if (mmax > 64) mmax = 64;
      end
      for (int r = 0; r < rows; r++) begin
         load_row(r, kv[FIELD_WIDTH-1:0], mv[FIELD_WIDTH-1:0]);
         if (r < rows - 1) begin
            kv = kv + random_step(kmax, flat_pct);
            mv = mv - random_step(mmax, flat_pct);
         end
      end
   endtask

   // mostly in-range queries, plus exact rows, out-of-range, unused action
   // and loads to rows beyond the ones in use
   task automatic run_conversions(int count);
      int sel;
      int last;
      int row;
      logic [1:0] act;
      logic [FIELD_WIDTH-1:0] q;
      logic [FIELD_WIDTH-1:0] lo;
      logic [FIELD_WIDTH-1:0] hi;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         last = plan_rows - 1;
         act = $urandom_range(0, 1) ? ACTION_K_TO_MV : ACTION_MV_TO_K;
         lo = (act == ACTION_K_TO_MV) ? plan_kelvin[0] : plan_millivolts[last];
         hi = (act == ACTION_K_TO_MV) ? plan_kelvin[last] : plan_millivolts[0];
         q = $urandom;
         if (sel < 70) begin
            if (lo <= hi) q = pick(lo, hi);
         end else if (sel < 82) begin
            row = $urandom_range(0, last);
            q = (act == ACTION_K_TO_MV) ? plan_kelvin[row] : plan_millivolts[row];
         end else if (sel < 92) begin
            if ($urandom_range(0, 1) && lo != 0) q = pick('0, lo - 1);
            else if (hi != '1) q = pick(hi + 1, '1);
         end else if (sel < 95) begin
            act = ACTION_UNUSED;
         end else if (last < ROWS_MAX - 1) begin
            act = ACTION_LOAD;
         end else begin
            q = $urandom_range(0, 1) ? '1 : '0;
         end
         if (act == ACTION_LOAD)
            load_row($urandom_range(last + 1, ROWS_MAX - 1), $urandom, $urandom);
         else convert(act, q);
      end
   endtask

   task automatic test_default_rows();
      load_row(0, '0, '1);
      load_row(1, '1, '0);
      convert(ACTION_K_TO_MV, '0);
      convert(ACTION_K_TO_MV, '1);
      convert(ACTION_K_TO_MV, 32'h8000_0000);
      convert(ACTION_MV_TO_K, '0);
      convert(ACTION_MV_TO_K, '1);
      convert(ACTION_MV_TO_K, 32'h1234_5678);
      convert(ACTION_UNUSED, 32'h5A5A_5A5A);
      load_row(ROWS_MAX - 1, '1, '1);
      // equal kelvin rows: zero divisor
      load_row(0, 32'h0064_0000, 32'h01F4_0000);
      load_row(1, 32'h0064_0000, 32'h00C8_0000);
      convert(ACTION_K_TO_MV, 32'h0064_0000);
      convert(ACTION_MV_TO_K, 32'h0100_0000);
      convert(ACTION_K_TO_MV, 32'h0063_FFFF);
      convert(ACTION_K_TO_MV, 32'h0064_0001);
      // equal millivolt rows
      load_row(1, 32'h012C_0000, 32'h01F4_0000);
      convert(ACTION_MV_TO_K, 32'h01F4_0000);
      convert(ACTION_MV_TO_K, 32'h01F4_0001);
      convert(ACTION_MV_TO_K, 32'h01F3_FFFF);
      convert(ACTION_K_TO_MV, 32'h00C8_0000);
   endtask

   task automatic test_full_table();
      set_row_count(9'd511);
      load_sorted_table(ROWS_MAX, 5);
      run_conversions(80);
   endtask

   task automatic test_row_count_clamp();
      logic [COUNT_FIELD_WIDTH-1:0] counts [5];
      counts = '{9'd0, 9'd1, 9'd257, 9'd256, 9'd2};
      foreach (counts[i]) begin
         set_row_count(counts[i]);
         run_conversions(20);
      end
   endtask

   task automatic test_sorted_tables();
      int sizes [7];
      sizes = '{3, 4, 9, 17, 33, $urandom_range(5, 48), $urandom_range(2, 64)};
      foreach (sizes[i]) begin
         set_row_count(COUNT_FIELD_WIDTH'(sizes[i]));
         load_sorted_table(sizes[i], (i == 6) ? 40 : 10);
         run_conversions(25);
      end
   endtask

   task automatic test_unsorted_table();
      int rows;
      rows = $urandom_range(4, 16);
      set_row_count(COUNT_FIELD_WIDTH'(rows));
      load_row(0, $urandom_range(0, 1000), 32'hFFFF_FFFF - $urandom_range(0, 1000));
      for (int r = 1; r < rows - 1; r++) load_row(r, $urandom, $urandom);
      load_row(rows - 1, 32'hFFFF_FFFF - $urandom_range(0, 1000), $urandom_range(0, 1000));
      run_conversions(40);
   endtask

   // sorted table broken up by stray loads and raw random items
   task automatic test_broken_sequences();
      set_row_count(COUNT_FIELD_WIDTH'($urandom_range(2, 24)));
      load_sorted_table(plan_rows, 10);
      repeat (8) begin
         run_conversions(5);
         load_row($urandom_range(0, plan_rows - 1), $urandom, $urandom);
         convert(2'($urandom_range(1, 3)), $urandom);
      end
   endtask

   task automatic test_no_idle();
      wait_drained();
      idle_on = 1'b0;
      set_row_count(COUNT_FIELD_WIDTH'($urandom_range(10, 100)));
      load_sorted_table(plan_rows, 10);
      run_conversions(60);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_rows();
      test_full_table();
      test_row_count_clamp();
      test_sorted_tables();
      test_unsorted_table();
      test_broken_sequences();
      test_no_idle();
      wait_drained();
      repeat (100) @(posedge clock);
      $display("covered %0d row loads, %0d conversions, %0d out-of-range or unused items",
               loaded_count, converted_count, range_count);
      $display("across %0d row-count writes incl. clamped values, sorted, flat and unsorted tables",
               csr_writes);
      if (error_count == 0 && awaited.size() == 0) begin
         $display("** sensor_table_interpolator_core: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count, awaited.size());
         $display("** sensor_table_interpolator_core: FAILED **");
      end
      $finish;
   end

endmodule
